### sv/ibts_pkg.sv
package ibts_pkg;

  // Number of entries in the level-ordered node store.
  localparam int NODE_COUNT = 127;

  // Index of a stored entry, and a wider address that can hold child
  // positions beyond the end of the store.
  localparam int IDX_W  = $clog2(NODE_COUNT);
  localparam int ADDR_W = IDX_W + 2;
  localparam int POS_W  = ADDR_W + 8;

  localparam int VAL_W   = 16;
  localparam int FUNC_W  = 3;
  localparam int LEVEL_W = 3;
  localparam int ORDER_W = 7;
  localparam int DEPTH_W = 3;

  typedef logic [VAL_W-1:0]   val_t;
  typedef logic [FUNC_W-1:0]  func_t;
  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [ORDER_W-1:0] order_t;
  typedef logic [DEPTH_W-1:0] depth_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [ADDR_W-1:0]  addr_t;

  // Operation codes.
  localparam func_t F_CLEAR  = 3'd0;
  localparam func_t F_ASSIGN = 3'd1;
  localparam func_t F_READ   = 3'd2;
  localparam func_t F_QUERY  = 3'd3;
  localparam func_t F_STATUS = 3'd4;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_ASG_P,
    S_ASG_C1,
    S_ASG_C2,
    S_RD,
    S_Q_ROOT,
    S_Q_SCAN,
    S_Q_PAR,
    S_Q_LEFT,
    S_Q_RIGHT,
    S_Q_SIB,
    S_ST_ROOT,
    S_ST_SCAN,
    S_DONE
  } state_t;

  // One result item as it is built up by the sequencer.
  typedef struct packed {
    logic   ok;
    val_t   node_value;
    val_t   parent_value;
    val_t   left_value;
    val_t   right_value;
    val_t   left_sibling_value;
    val_t   right_sibling_value;
    depth_t tree_depth;
    logic   tree_empty;
  } res_t;

  // Tree depth from the count of entries up to the last occupied one:
  // the bit length of the count, saturated at seven levels.
  function automatic depth_t depth_of(input addr_t count);
    int j;
    j = 0;
    for (int b = 0; b < ADDR_W; b++) begin
      if (count[b]) begin
        j = b + 1;
      end
    end
    if (j > 7) begin
      j = 7;
    end
    return DEPTH_W'(j);
  endfunction

endpackage

### sv/implicit_binary_tree_store.sv
// Binary tree store kept in level order in one memory of NODE_COUNT 16-bit
// entries, with a zero value marking an empty node. Every operation runs on
// a small sequencer around a single memory read port, one entry per cycle,
// and returns one result transfer. Status scans every entry of the store, and
// query scans entries until the key is found or the store ends. The block
// takes no new item while one is in work, but a finished result may wait on
// the output while the next item starts. Each entry has a valid bit that
// reset and clear drop at once, so there is no clearing pass and the store
// is usable right after reset.
module implicit_binary_tree_store (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  ibts_pkg::func_t  func,
  input  ibts_pkg::level_t level,
  input  ibts_pkg::order_t order,
  input  ibts_pkg::val_t   new_value,
  input  ibts_pkg::val_t   search_key,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            ok,
  output ibts_pkg::val_t   node_value,
  output ibts_pkg::val_t   parent_value,
  output ibts_pkg::val_t   left_value,
  output ibts_pkg::val_t   right_value,
  output ibts_pkg::val_t   left_sibling_value,
  output ibts_pkg::val_t   right_sibling_value,
  output ibts_pkg::depth_t tree_depth,
  output logic            tree_empty
);
  import ibts_pkg::*;

  state_t state, state_next;

  func_t  func_q;
  level_t level_q;
  order_t order_q;
  val_t   val_q;
  val_t   key_q;

  idx_t  idx, idx_next;
  addr_t count, count_next;
  res_t  res, res_next;
  res_t  out_res;

  logic [NODE_COUNT-1:0] vld;
  logic                  rd_hit;

  logic  rd_en;
  addr_t rd_addr;
  logic  rd_in_range;
  logic  wr_en;
  idx_t  wr_addr;
  logic  clr_all;
  val_t  ram_q;
  val_t  rd_value;

  logic [POS_W-1:0] span;
  logic [POS_W-1:0] pos_full;
  logic             pos_ok;
  idx_t             pos_idx;
  addr_t            idx_w;
  logic             last;
  logic             match;
  logic             out_free;
  logic             in_xfer;

  // Node memory.
  ibts_ram #(
    .WIDTH(VAL_W),
    .DEPTH(NODE_COUNT)
  ) u_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(val_q),
    .re   (rd_en),
    .raddr(rd_addr[IDX_W-1:0]),
    .rdata(ram_q)
  );

  // Decode of the request and of the entry that arrives from the memory.
  always_comb begin
    span     = POS_W'(1) << (level_q - LEVEL_W'(1));
    pos_full = span + POS_W'(order_q) - POS_W'(2);
    pos_ok   = (level_q != '0) && (order_q != '0) && (POS_W'(order_q) <= span) &&
               (pos_full < POS_W'(NODE_COUNT));
    pos_idx  = pos_full[IDX_W-1:0];
    idx_w    = ADDR_W'(idx);
    last     = (idx == IDX_W'(NODE_COUNT - 1));
    rd_value = rd_hit ? ram_q : '0;
    match    = (rd_value == key_q);
    out_free = !out_valid || out_ready;
    in_xfer  = in_valid && in_ready;
    rd_in_range = (rd_addr < ADDR_W'(NODE_COUNT));
  end

  // Next state of the sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (in_valid) state_next = S_START;
      S_START: begin
        case (func_q)
          F_ASSIGN: begin
            if (!pos_ok) begin
              state_next = S_DONE;
            end else if (val_q != '0) begin
              state_next = (pos_idx == '0) ? S_DONE : S_ASG_P;
            end else begin
              state_next = S_ASG_C1;
            end
          end
          F_READ:   state_next = pos_ok ? S_RD : S_DONE;
          F_QUERY:  state_next = S_Q_ROOT;
          F_STATUS: state_next = S_ST_ROOT;
          default:  state_next = S_DONE;
        endcase
      end
      S_ASG_P:   state_next = S_DONE;
      S_ASG_C1:  state_next = (rd_value != '0) ? S_DONE : S_ASG_C2;
      S_ASG_C2:  state_next = S_DONE;
      S_RD:      state_next = S_DONE;
      S_Q_ROOT:  state_next = (rd_value == '0 || key_q == '0) ? S_DONE : S_Q_SCAN;
      S_Q_SCAN: begin
        if (match) begin
          state_next = S_Q_PAR;
        end else if (last) begin
          state_next = S_DONE;
        end
      end
      S_Q_PAR:   state_next = S_Q_LEFT;
      S_Q_LEFT:  state_next = S_Q_RIGHT;
      S_Q_RIGHT: state_next = S_Q_SIB;
      S_Q_SIB:   state_next = S_DONE;
      S_ST_ROOT: state_next = S_ST_SCAN;
      S_ST_SCAN: if (last) state_next = S_DONE;
      S_DONE:    if (out_free) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // Memory accesses and result fields for each step.
  always_comb begin
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = idx;
    clr_all    = 1'b0;
    idx_next   = idx;
    count_next = count;
    res_next   = res;
    in_ready   = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          res_next = '0;
        end
      end
      S_START: begin
        case (func_q)
          F_CLEAR: begin
            clr_all     = 1'b1;
            res_next.ok = 1'b1;
          end
          F_ASSIGN: begin
            if (pos_ok) begin
              idx_next = pos_idx;
              if (val_q != '0) begin
                if (pos_idx == '0) begin
                  wr_en       = 1'b1;
                  wr_addr     = pos_idx;
                  res_next.ok = 1'b1;
                end else begin
                  rd_en   = 1'b1;
                  rd_addr = (ADDR_W'(pos_idx) - ADDR_W'(1)) >> 1;
                end
              end else begin
                rd_en   = 1'b1;
                rd_addr = (ADDR_W'(pos_idx) << 1) + ADDR_W'(1);
              end
            end
          end
          F_READ: begin
            if (pos_ok) begin
              idx_next = pos_idx;
              rd_en    = 1'b1;
              rd_addr  = ADDR_W'(pos_idx);
            end
          end
          F_QUERY, F_STATUS: begin
            rd_en   = 1'b1;
            rd_addr = '0;
          end
          default: begin
          end
        endcase
      end
      S_ASG_P: begin
        if (rd_value != '0) begin
          wr_en       = 1'b1;
          res_next.ok = 1'b1;
        end
      end
      S_ASG_C1: begin
        if (rd_value == '0) begin
          rd_en   = 1'b1;
          rd_addr = (idx_w << 1) + ADDR_W'(2);
        end
      end
      S_ASG_C2: begin
        if (rd_value == '0) begin
          wr_en       = 1'b1;
          res_next.ok = 1'b1;
        end
      end
      S_RD: begin
        res_next.ok         = 1'b1;
        res_next.node_value = rd_value;
      end
      S_Q_ROOT: begin
        if (rd_value != '0 && key_q != '0) begin
          idx_next = IDX_W'(1);
          rd_en    = 1'b1;
          rd_addr  = ADDR_W'(1);
        end
      end
      S_Q_SCAN: begin
        if (match) begin
          rd_en   = 1'b1;
          rd_addr = (idx_w - ADDR_W'(1)) >> 1;
        end else if (!last) begin
          idx_next = idx + IDX_W'(1);
          rd_en    = 1'b1;
          rd_addr  = idx_w + ADDR_W'(1);
        end
      end
      S_Q_PAR: begin
        res_next.parent_value = rd_value;
        rd_en   = 1'b1;
        rd_addr = (idx_w << 1) + ADDR_W'(1);
      end
      S_Q_LEFT: begin
        res_next.left_value = rd_value;
        rd_en   = 1'b1;
        rd_addr = (idx_w << 1) + ADDR_W'(2);
      end
      S_Q_RIGHT: begin
        res_next.right_value = rd_value;
        rd_en   = 1'b1;
        rd_addr = idx[0] ? (idx_w + ADDR_W'(1)) : (idx_w - ADDR_W'(1));
      end
      S_Q_SIB: begin
        res_next.ok = 1'b1;
        if (idx[0]) begin
          res_next.right_sibling_value = rd_value;
        end else begin
          res_next.left_sibling_value = rd_value;
        end
      end
      S_ST_ROOT: begin
        res_next.ok         = (rd_value != '0);
        res_next.node_value = rd_value;
        res_next.tree_empty = (rd_value == '0);
        count_next = (rd_value != '0) ? ADDR_W'(1) : '0;
        idx_next   = IDX_W'(1);
        rd_en      = 1'b1;
        rd_addr    = ADDR_W'(1);
      end
      S_ST_SCAN: begin
        if (rd_value != '0) begin
          count_next = idx_w + ADDR_W'(1);
        end
        if (last) begin
          res_next.tree_depth = depth_of(count_next);
        end else begin
          idx_next = idx + IDX_W'(1);
          rd_en    = 1'b1;
          rd_addr  = idx_w + ADDR_W'(1);
        end
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Sequencer and per-entry valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      vld    <= '0;
      rd_hit <= 1'b0;
    end else begin
      state  <= state_next;
      rd_hit <= rd_en && rd_in_range && vld[rd_addr[IDX_W-1:0]];
      if (clr_all) begin
        vld <= '0;
      end else if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
    end
  end

  // Request fields, scan position and result under construction.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      func_q  <= func;
      level_q <= level;
      order_q <= order;
      val_q   <= new_value;
      key_q   <= search_key;
    end
    idx   <= idx_next;
    count <= count_next;
    res   <= res_next;
  end

  // Output register: a finished result waits here for its transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_res <= res;
    end
  end

  assign ok                  = out_res.ok;
  assign node_value          = out_res.node_value;
  assign parent_value        = out_res.parent_value;
  assign left_value          = out_res.left_value;
  assign right_value         = out_res.right_value;
  assign left_sibling_value  = out_res.left_sibling_value;
  assign right_sibling_value = out_res.right_sibling_value;
  assign tree_depth          = out_res.tree_depth;
  assign tree_empty          = out_res.tree_empty;

  // The memory is never read and written in the same cycle.
  a_no_rd_wr: assert property (@(posedge clk) disable iff (rst)
    !(rd_en && wr_en))
    else $error("memory read and write in the same cycle");

  // Writes only come from the assign steps.
  a_wr_assign: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (func_q == F_ASSIGN) &&
              (state == S_START || state == S_ASG_P || state == S_ASG_C2))
    else $error("memory write outside an assign");

  // A clear drops every valid bit in the next cycle.
  a_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_START && func_q == F_CLEAR) |=> (vld == '0))
    else $error("clear left valid entries");

  // Scans stay inside the store.
  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_Q_SCAN || state == S_ST_SCAN) |->
      (ADDR_W'(idx) < ADDR_W'(NODE_COUNT)))
    else $error("scan index beyond the store");

  // A result is offered only once the sequencer has finished.
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result offered before the operation finished");

endmodule

### sv/ibts_ram.sv
module ibts_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
